// ===== rtl/apsp_pkg.sv =====
// Package for the all-pairs shortest path core: shared types, constants and the relax function.
// No dependencies.
package apsp_pkg;
	localparam int DistW = 21;
	localparam int WeightW = 17;
	localparam logic [DistW-1:0] NoEdge = '1;
	localparam logic [DistW-1:0] DistMax = 21'd1048575;
	localparam logic [3:0] RegVertexCount = 4'd0;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RELAX,
		ST_EMIT
	} state_t;

	// Relax one entry: cur vs a + b, with negative meaning no edge.
	function automatic logic [DistW-1:0] relax_entry(input logic [DistW-1:0] cur,
			input logic [DistW-1:0] a, input logic [DistW-1:0] b);
		logic [DistW:0] sum;
		logic [DistW-1:0] s;
		begin
			sum = {1'b0, a} + {1'b0, b};
			s = (sum > {1'b0, DistMax}) ? DistMax : sum[DistW-1:0];
			if (a[DistW-1] || b[DistW-1])
				relax_entry = cur;
			else if (cur[DistW-1] || s < cur)
				relax_entry = s;
			else
				relax_entry = cur;
		end
	endfunction
endpackage

// ===== rtl/apsp_cell.sv =====
// One relaxation cell: holds one matrix column and relaxes its entry of the row in flight.
// Depends on apsp_pkg.
module apsp_cell import apsp_pkg::*; #(
	parameter int DEPTH = 8,
	parameter int IW = 3
) (
	input  logic             clk,
	input  logic             ld_en,
	input  logic [IW-1:0]    ld_row,
	input  logic [DistW-1:0] ld_data,
	input  logic             wb_en,
	input  logic [IW-1:0]    wb_row,
	input  logic [IW-1:0]    rd_row,
	input  logic [IW-1:0]    k_row,
	input  logic [DistW-1:0] a,
	output logic [DistW-1:0] cur
);
	logic [DistW-1:0] entry_q [DEPTH];
	logic [DistW-1:0] res_q;

	assign cur = entry_q[rd_row];

	always_ff @(posedge clk) begin
		res_q <= relax_entry(entry_q[rd_row], a, entry_q[k_row]);
		if (ld_en)
			entry_q[ld_row] <= ld_data;
		else if (wb_en)
			entry_q[wb_row] <= res_q;
	end
endmodule

// ===== rtl/all_pairs_shortest_path_core.sv =====
// All-pairs shortest path core: top level with load, relax and emit control.
// Depends on apsp_pkg and apsp_cell.
//
// Load N*N edge weights row-major (N = vertex_count, clamped to 1..MAX_VERTICES),
// one word per cycle; -1 (any negative) means no edge. After the last word the
// core runs Floyd-Warshall with a row of MAX_VERTICES cells, one per column,
// each cell holding its own matrix column: each relax step updates a whole
// row i for pivot k by an issue and then a write back. Then the matrix is
// emitted row-major at one word per cycle while out_stall is low, with
// last_entry on the final word. No input is accepted while relaxing or
// emitting. The matrix store has no reset; all entries are written by the
// load before they are read.
module all_pairs_shortest_path_core import apsp_pkg::*; #(
	parameter int MAX_VERTICES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [WeightW-1:0]  edge_weight,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [DistW-1:0]    distance,
	output logic [2:0]          from_vertex,
	output logic [2:0]          to_vertex,
	output logic                last_entry
);
	localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NW = $clog2(MAX_VERTICES + 1);

	logic [3:0]       vcount_q;
	logic [NW-1:0]    n;
	state_t           state_q, state_d;
	logic [IW-1:0]    row_q, col_q, k_q;
	logic             wr_cfg;
	logic             in_acc, out_acc;

	// Entry of the current row held by each column cell.
	logic [DistW-1:0] cur_w [MAX_VERTICES];
	logic [DistW-1:0] ld_word;
	logic             relax_en;

	assign pready = 1'b1;
	assign wr_cfg = psel && penable && pwrite && (paddr == RegVertexCount[1:0]);
	assign prdata = (paddr == RegVertexCount[1:0]) ? {28'd0, vcount_q} : 32'd0;

	// Clamp side length.
	always_comb begin
		if (vcount_q == 4'd0)
			n = NW'(1);
		else if (32'(vcount_q) > MAX_VERTICES)
			n = NW'(MAX_VERTICES);
		else
			n = NW'(vcount_q);
	end

	assign in_stall = (state_q != ST_LOAD);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = (state_q == ST_EMIT);
	assign out_acc = out_valid && !out_stall;
	assign relax_en = (state_q == ST_RELAX);

	logic last_col, last_row, last_k;
	assign last_col = (NW'(col_q) == n - NW'(1));
	assign last_row = (NW'(row_q) == n - NW'(1));
	assign last_k   = (NW'(k_q) == n - NW'(1));

	// Map the incoming weight: any negative becomes no edge.
	assign ld_word = edge_weight[WeightW-1] ? NoEdge : DistW'(edge_weight[WeightW-2:0]);

	// Pipeline: cell results are registered and land in the next cycle; track that row.
	logic             wb_s1;
	logic [IW-1:0]    wb_row_s1;

	// Cells: cell j relaxes mat[row][j] via pivot k. In-place use of row k
	// is safe since mat[k][k] can only shrink and path via k to k is unchanged.
	for (genvar j = 0; j < MAX_VERTICES; j++) begin : g_cell
		apsp_cell #(
			.DEPTH (MAX_VERTICES),
			.IW    (IW)
		) u_cell (
			.clk     (clk),
			.ld_en   (in_acc && (col_q == IW'(j))),
			.ld_row  (row_q),
			.ld_data (ld_word),
			.wb_en   (wb_s1),
			.wb_row  (wb_row_s1),
			.rd_row  (row_q),
			.k_row   (k_q),
			.a       (cur_w[k_q]),
			.cur     (cur_w[j])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:  if (in_acc && last_row && last_col) state_d = ST_RELAX;
			ST_RELAX: if (wb_s1 && last_k && last_row) state_d = ST_EMIT;
			ST_EMIT:  if (out_acc && last_row && last_col) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	// Relax issues one row at a time: issue, then write back, so the
	// next row sees the updated matrix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 4'd8;
			state_q <= ST_LOAD;
			row_q <= '0;
			col_q <= '0;
			k_q <= '0;
			wb_s1 <= 1'b0;
			wb_row_s1 <= '0;
		end else begin
			state_q <= state_d;
			wb_s1 <= relax_en && !wb_s1;
			wb_row_s1 <= row_q;
			if (wr_cfg) begin
				vcount_q <= pwdata[3:0];
				row_q <= '0;
				col_q <= '0;
				state_q <= ST_LOAD;
			end else if (in_acc || out_acc) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else
					col_q <= col_q + 1'b1;
				k_q <= '0;
			end else if (wb_s1) begin
				if (last_row) begin
					row_q <= '0;
					k_q <= last_k ? '0 : k_q + 1'b1;
				end else
					row_q <= row_q + 1'b1;
			end
		end
	end

	assign distance = cur_w[col_q];
	assign from_vertex = 3'(row_q);
	assign to_vertex = 3'(col_q);
	assign last_entry = last_row && last_col;

`ifndef NO_ASSERTIONS
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_LOAD |-> !in_acc) else $error("input taken while busy");
	a_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_EMIT) else $error("output outside emit");
	a_wb_relax: assert property (@(posedge clk) disable iff (!arst_n)
		wb_s1 |-> $past(relax_en)) else $error("writeback without relax");
`endif
endmodule

// ===== dv/all_pairs_shortest_path_core_test.sv =====
// Self-checking testbench for the all-pairs shortest path core.
// Depends on apsp_pkg and the all_pairs_shortest_path_core RTL.
`timescale 1ns / 1ps

module all_pairs_shortest_path_core_test;
	import apsp_pkg::*;

	typedef struct {
		logic [DistW-1:0] distance;
		logic [2:0]       from_vertex;
		logic [2:0]       to_vertex;
		logic             last_entry;
	} dist_word_t;

	// Shortest-path board: mirrors the matrix store and holds the words still owed.
	class path_board;
		int               side_reg;
		int               dist_mat [64];
		int               loaded;
		dist_word_t       owed [$];
		int               errors;
		int               words_seen;
		int               matrices_seen;

		function new();
			side_reg = 8;
			loaded = 0;
			errors = 0;
			words_seen = 0;
			matrices_seen = 0;
		endfunction

		function void set_side(int v);
			side_reg = v & 15;
			loaded = 0;
		endfunction

		function int side();
			if (side_reg < 1) return 1;
			if (side_reg > 8) return 8;
			return side_reg;
		endfunction

		// Note one accepted edge weight; on the final word of a matrix relax and queue it.
		function void note_weight(logic [WeightW-1:0] raw);
			int n, total, a, b, s;
			dist_word_t w;
			n = side();
			total = n * n;
			if (loaded >= total) loaded = 0;
			dist_mat[loaded] = raw[WeightW-1] ? -1 : int'(raw);
			loaded++;
			if (loaded < total) return;
			for (int k = 0; k < n; k++)
				for (int i = 0; i < n; i++)
					for (int j = 0; j < n; j++) begin
						a = dist_mat[i*n+k];
						b = dist_mat[k*n+j];
						if (a < 0 || b < 0) continue;
						s = a + b;
						if (s > 1048575) s = 1048575;
						if (dist_mat[i*n+j] < 0 || s < dist_mat[i*n+j])
							dist_mat[i*n+j] = s;
					end
			for (int e = 0; e < total; e++) begin
				w.distance = dist_mat[e][DistW-1:0];
				w.from_vertex = 3'(e / n);
				w.to_vertex = 3'(e % n);
				w.last_entry = (e + 1 == total);
				owed.push_back(w);
			end
			loaded = 0;
		endfunction

		function void check_word(dist_word_t got);
			dist_word_t exp_w;
			words_seen++;
			if (owed.size() == 0) begin
				$error("unexpected output word: distance %0h", got.distance);
				errors++;
				return;
			end
			exp_w = owed.pop_front();
			if (got.distance !== exp_w.distance) begin
				$error("distance: expected %0h, got %0h", exp_w.distance, got.distance);
				errors++;
			end
			if (got.from_vertex !== exp_w.from_vertex) begin
				$error("from_vertex: expected %0d, got %0d", exp_w.from_vertex,
					got.from_vertex);
				errors++;
			end
			if (got.to_vertex !== exp_w.to_vertex) begin
				$error("to_vertex: expected %0d, got %0d", exp_w.to_vertex, got.to_vertex);
				errors++;
			end
			if (got.last_entry !== exp_w.last_entry) begin
				$error("last_entry: expected %0b, got %0b", exp_w.last_entry,
					got.last_entry);
				errors++;
			end
			if (got.last_entry) matrices_seen++;
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [1:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [WeightW-1:0] edge_weight = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [DistW-1:0]   distance;
	logic [2:0]         from_vertex;
	logic [2:0]         to_vertex;
	logic               last_entry;

	path_board board = new();
	int        cycle_count = 0;
	int        words_sent = 0;
	bit        quiet = 1'b0;   // no idling on either side while set
	int        settings_used = 0;

	localparam int CycleLimit = 1000000;

	all_pairs_shortest_path_core uut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort on a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("all_pairs_shortest_path_core verification failed");
			$finish;
		end
	end

	// Receiver: unless quiet, may stall before each word, then take it. Sample at the falling
	// edge, where everything driven at the rising edge has settled.
	initial begin : receiver
		int gap;
		dist_word_t got;
		@(posedge arst_n);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				out_stall <= 1'b0;
			end
			forever begin
				@(negedge clk);
				if (out_valid) begin
					got.distance = distance;
					got.from_vertex = from_vertex;
					got.to_vertex = to_vertex;
					got.last_entry = last_entry;
					board.check_word(got);
					@(posedge clk);
					break;
				end
				@(posedge clk);
			end
		end
	end

	// Send one word; called and returning at a rising edge.
	task automatic send_word(logic [WeightW-1:0] w);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		edge_weight <= w;
		forever begin
			@(negedge clk);
			if (!in_stall) begin
				board.note_weight(w);
				words_sent++;
				@(posedge clk);
				break;
			end
			@(posedge clk);
		end
	endtask

	// Drop valid and let the core drain before touching the register.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.owed.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Two-phase register write while the core is idle.
	task automatic write_side(int v);
		settle();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= RegVertexCount[1:0];
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.set_side(v);
		settings_used++;
	endtask

	// Weight mix: no-edge, other negatives, extremes, short and full-range lengths.
	function automatic logic [WeightW-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0, 1: return '1;
			2: return {1'b1, 16'($urandom)};
			3: return 17'd65535;
			4: return 17'd0;
			5, 6: return 17'($urandom_range(0, 40));
			default: return {1'b0, 16'($urandom)};
		endcase
	endfunction

	initial begin
		int n, reps, part;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single-vertex matrices at the field extremes.
		write_side(1);
		send_word(17'd65535);
		send_word('1);
		send_word(17'd0);
		send_word(17'h10005);      // negative other than no-edge
		send_word(17'h10000);
		write_side(0);             // zero side behaves as one
		send_word(17'd7);
		send_word(17'h0AAAA);
		// Two vertices: direct edges that no detour beats, and missing edges that stay missing.
		write_side(2);
		send_word(17'd5);
		send_word(17'd100);
		send_word(17'd1);
		send_word(17'd3);
		send_word('1);
		send_word(17'd2);
		send_word('1);
		send_word(17'd0);
		// Abandon a partial load: the rewrite restarts counting.
		write_side(3);
		send_word(17'd9);
		send_word(17'd4);
		send_word(17'd1);
		write_side(2);
		send_word(17'd1);
		send_word(17'd2);
		send_word(17'd3);
		send_word(17'd4);

		// Random phases: mostly small sides, occasionally larger ones up to and beyond the largest.
		while (words_sent < 300) begin
			if ($urandom_range(0, 5) == 0) n = $urandom_range(5, 15);
			else n = $urandom_range(0, 4);
			quiet = ($urandom_range(0, 3) == 0);
			write_side(n);
			n = board.side();
			if ($urandom_range(0, 7) == 0) begin
				part = $urandom_range(1, n * n);
				repeat (part - 1) send_word(pick_weight());
				write_side(board.side_reg);
			end
			reps = (n > 4) ? 1 : $urandom_range(1, 3);
			repeat (reps * n * n) send_word(pick_weight());
		end
		write_side(15);
		repeat (64) send_word(17'($urandom_range(0, 65535)));

		quiet = 1'b0;
		settle();
		repeat (30) @(posedge clk);
		$display("sent %0d edge weights over %0d register settings", words_sent,
			settings_used);
		$display("checked %0d distance words in %0d matrices", board.words_seen,
			board.matrices_seen);
		if (board.errors == 0 && board.owed.size() == 0) begin
			$display("all_pairs_shortest_path_core verification clean");
		end else begin
			$display("all_pairs_shortest_path_core verification failed");
		end
		$finish;
	end
endmodule

// ===== all_pairs_shortest_path_core.f =====
rtl/apsp_pkg.sv
rtl/apsp_cell.sv
rtl/all_pairs_shortest_path_core.sv
dv/all_pairs_shortest_path_core_test.sv
